// File: rtl/sdt_pkg.sv
package sdt_pkg;

  localparam int SLOT_W = 13;
  localparam int CNT_W  = 14;
  localparam int WORD_W = 64;

  localparam int P_BIT = 47;
  localparam logic [31:0] GRAN_LIMIT = 32'd4096;

  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_RESERVE  = 2'd1;
  localparam logic [1:0] KIND_DELETE   = 2'd2;
  localparam logic [1:0] KIND_SELECTOR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // first free entry found by the search unit
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } free_slot_t;

  // one write to the entry store
  typedef struct packed {
    logic              we;
    logic              clr_p;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
  } store_wr_t;

  // x86 descriptor: limit, base, access byte, flags
  function automatic logic [WORD_W-1:0] encode_desc(
    input logic [1:0]  dpl,
    input logic        sys,
    input logic [3:0]  typ,
    input logic [31:0] base,
    input logic [31:0] lim
  );
    logic        gran;
    logic [19:0] l;
    logic [7:0]  acc;
    gran = (lim >= GRAN_LIMIT);
    l    = gran ? lim[31:12] : lim[19:0];
    acc  = {1'b1, dpl, ~sys, typ};
    return {base[31:24], gran, 1'b1, 1'b0, 1'b0, l[19:16], acc, base[23:0], l[15:0]};
  endfunction

endpackage

// File: rtl/sdt_free_find.sv
module sdt_free_find #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                      clk,
  input  logic [MAX_ENTRIES-1:0]    present,
  input  logic [sdt_pkg::CNT_W-1:0] cnt,
  output sdt_pkg::free_slot_t       free_slot
);

  localparam int GRP   = 16;
  localparam int GRP_W = 4;
  localparam int NGRP  = (MAX_ENTRIES + GRP - 1) / GRP;

  logic [NGRP-1:0]            any_nxt;
  logic [NGRP-1:0]            any_r;
  logic [NGRP-1:0][GRP_W-1:0] off_nxt;
  logic [NGRP-1:0][GRP_W-1:0] off_r;

  // first level: one small priority encoder per group of sixteen entries
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      any_nxt[g] = 1'b0;
      off_nxt[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if ((g * GRP + j) >= 1 && (g * GRP + j) < MAX_ENTRIES &&
            sdt_pkg::CNT_W'(g * GRP + j) < cnt) begin
          if (!present[(g * GRP + j) % MAX_ENTRIES]) begin
            any_nxt[g] = 1'b1;
            off_nxt[g] = GRP_W'(j);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    any_r <= any_nxt;
    off_r <= off_nxt;
  end

  // second level: lowest group with a free entry
  always_comb begin
    free_slot.found = 1'b0;
    free_slot.slot  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (any_r[g]) begin
        free_slot.found = 1'b1;
        free_slot.slot  = sdt_pkg::SLOT_W'(g * GRP + int'(off_r[g]));
      end
    end
  end

endmodule

// File: rtl/sdt_entry_store.sv
module sdt_entry_store #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [sdt_pkg::SLOT_W-1:0] rd_slot,
  input  sdt_pkg::store_wr_t         wr
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [sdt_pkg::WORD_W-1:0] mem [MAX_ENTRIES];
  logic [sdt_pkg::WORD_W-1:0] rd_q_r;
  logic [sdt_pkg::WORD_W-1:0] wdata;

  // delete keeps the stored word and drops only its present flag
  always_comb begin
    wdata = wr.word;
    if (wr.clr_p) begin
      wdata = rd_q_r;
      wdata[sdt_pkg::P_BIT] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem[rd_slot[AW-1:0]];
    end
    if (wr.we) begin
      mem[wr.slot[AW-1:0]] <= wdata;
    end
  end

endmodule

// File: rtl/segment_descriptor_table.sv
// segment descriptor table
// keeps up to MAX_ENTRIES x86 segment descriptors with a present flag each
// input channel (in_*): one request item per handshake; kind selects add at
// index, reserve first free entry from index 1, delete, or make selector
// result channel (out_*): one result item per request, in request order
// config channel (cfg_*): cfg_data sets the number of entries in use,
// capped at MAX_ENTRIES; always ready, write it only while the block is idle
// timing: an item is taken in the idle state and finished in the exec state
// once the result register is free; no new item is taken until it finishes;
// the result is registered on out_* as the item finishes
// the split into take and finish is set by the entry store read-modify-write
// and by the register between the two levels of the first-free search over the present flags
// a stalled receiver holds the result register; one more item can be
// taken meanwhile and waits in its finish cycle until the register frees
// reset clears all present flags, the entry count, the state and the result valid;
// descriptor words are not cleared
module segment_descriptor_table #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [sdt_pkg::SLOT_W-1:0]  in_slot_index,
  input  logic [1:0]                  in_privilege,
  input  logic                        in_is_system,
  input  logic [3:0]                  in_seg_type,
  input  logic [31:0]                 in_seg_base,
  input  logic [31:0]                 in_seg_limit,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_status,
  output logic [sdt_pkg::SLOT_W-1:0]  out_used_slot,
  output logic [15:0]                 out_selector,
  output logic [sdt_pkg::WORD_W-1:0]  out_entry_word,
  // entry count register
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sdt_pkg::CNT_W-1:0]   cfg_data
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [sdt_pkg::CNT_W-1:0] cnt_r;

  // captured request item
  logic [1:0]                 kind_r;
  logic [sdt_pkg::SLOT_W-1:0] slot_r;
  logic [1:0]                 priv_r;
  logic                       sys_r;
  logic [3:0]                 type_r;
  logic [31:0]                base_r;
  logic [31:0]                limit_r;

  logic [MAX_ENTRIES-1:0] present_r;

  logic                       out_valid_r;
  logic [1:0]                 status_r,   status_nxt;
  logic [sdt_pkg::SLOT_W-1:0] used_r,     used_nxt;
  logic [15:0]                sel_r,      sel_nxt;
  logic [sdt_pkg::WORD_W-1:0] word_r,     word_nxt;

  logic                       accept;
  logic                       exec_fire;
  logic                       in_range;
  logic                       set_p;
  logic                       clr_p;
  logic [sdt_pkg::WORD_W-1:0] enc_word;
  sdt_pkg::free_slot_t        free_slot;
  sdt_pkg::store_wr_t         store_wr;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  // finish only when the result register is free or being emptied
  assign exec_fire = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_used_slot  = used_r;
  assign out_selector   = sel_r;
  assign out_entry_word = word_r;

  sdt_free_find #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_free_find (
    .clk       (clk),
    .present   (present_r),
    .cnt       (cnt_r),
    .free_slot (free_slot)
  );

  // read the addressed entry as the item is taken, for delete
  sdt_entry_store #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_entry_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_slot (in_slot_index),
    .wr      (store_wr)
  );

  assign enc_word = sdt_pkg::encode_desc(priv_r, sys_r, type_r, base_r, limit_r);
  assign in_range = {1'b0, slot_r} < cnt_r;

  always_comb begin
    status_nxt = sdt_pkg::ST_OK;
    used_nxt   = slot_r;
    sel_nxt    = '0;
    word_nxt   = '0;
    set_p      = 1'b0;
    clr_p      = 1'b0;
    store_wr   = '0;
    if (kind_r == sdt_pkg::KIND_RESERVE) begin
      if (free_slot.found) begin
        used_nxt       = free_slot.slot;
        word_nxt       = enc_word;
        set_p          = 1'b1;
        store_wr.we    = exec_fire;
        store_wr.slot  = free_slot.slot;
        store_wr.word  = enc_word;
      end else begin
        status_nxt = sdt_pkg::ST_FULL;
        used_nxt   = '0;
      end
    end else if (!in_range) begin
      status_nxt = sdt_pkg::ST_RANGE;
    end else begin
      unique case (kind_r)
        sdt_pkg::KIND_ADD: begin
          word_nxt      = enc_word;
          set_p         = 1'b1;
          store_wr.we   = exec_fire;
          store_wr.slot = slot_r;
          store_wr.word = enc_word;
        end
        sdt_pkg::KIND_DELETE: begin
          clr_p          = 1'b1;
          store_wr.we    = exec_fire;
          store_wr.clr_p = 1'b1;
          store_wr.slot  = slot_r;
        end
        sdt_pkg::KIND_SELECTOR: begin
          // ti stays zero: table is global
          sel_nxt = {slot_r, 1'b0, priv_r};
        end
        default: begin
          status_nxt = sdt_pkg::ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      present_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cnt_r <= (cfg_data > sdt_pkg::CNT_W'(MAX_ENTRIES)) ?
                 sdt_pkg::CNT_W'(MAX_ENTRIES) : cfg_data;
      end
      if (exec_fire && set_p) begin
        present_r[store_wr.slot[AW-1:0]] <= 1'b1;
      end else if (exec_fire && clr_p) begin
        present_r[store_wr.slot[AW-1:0]] <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      slot_r  <= in_slot_index;
      priv_r  <= in_privilege;
      sys_r   <= in_is_system;
      type_r  <= in_seg_type;
      base_r  <= in_seg_base;
      limit_r <= in_seg_limit;
    end
    if (exec_fire) begin
      status_r <= status_nxt;
      used_r   <= used_nxt;
      sel_r    <= sel_nxt;
      word_r   <= word_nxt;
    end
  end

  // an item taken moves the block to its finish state
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("item taken but block not in finish state");

  // a reserved entry lies in 1 .. count-1
  a_reserve_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && kind_r == sdt_pkg::KIND_RESERVE && free_slot.found) |->
      (free_slot.slot != '0 && sdt_pkg::CNT_W'(free_slot.slot) < cnt_r))
    else $error("reserved entry outside the usable range");

  // a written entry is marked present afterwards
  a_written_present: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && set_p) |=> present_r[$past(store_wr.slot[AW-1:0])])
    else $error("written entry not marked present");

  // a result appears only from a finished item
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(exec_fire))
    else $error("result shown without a finished item");

endmodule

// File: test/tb_top.sv
module tb_top;

  localparam int NUM_ENTRIES = 256;   // block built with its default table depth
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int LONG_HOLD   = 120;   // receiver hold-off, long enough to back up the input
  localparam int STALL_LIMIT = 4000;  // cycles without any handshake before giving up
  localparam int NUM_PHASES  = 6;

  // one request item as it sits on the in_* ports
  typedef struct packed {
    logic [1:0]                 kind;
    logic [sdt_pkg::SLOT_W-1:0] slot;
    logic [1:0]                 priv;
    logic                       sys;
    logic [3:0]                 typ;
    logic [31:0]                base;
    logic [31:0]                limit;
  } request_t;

  // one result item as it shows on the out_* ports
  typedef struct packed {
    logic [1:0]                 status;
    logic [sdt_pkg::SLOT_W-1:0] used_slot;
    logic [15:0]                selector;
    logic [sdt_pkg::WORD_W-1:0] word;
  } outcome_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   in_kind;
  logic [sdt_pkg::SLOT_W-1:0]   in_slot_index;
  logic [1:0]                   in_privilege;
  logic                         in_is_system;
  logic [3:0]                   in_seg_type;
  logic [31:0]                  in_seg_base;
  logic [31:0]                  in_seg_limit;
  logic                         out_valid;
  logic                         out_ready;
  logic [1:0]                   out_status;
  logic [sdt_pkg::SLOT_W-1:0]   out_used_slot;
  logic [15:0]                  out_selector;
  logic [sdt_pkg::WORD_W-1:0]   out_entry_word;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [sdt_pkg::CNT_W-1:0]    cfg_data;

  segment_descriptor_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_slot_index  (in_slot_index),
    .in_privilege   (in_privilege),
    .in_is_system   (in_is_system),
    .in_seg_type    (in_seg_type),
    .in_seg_base    (in_seg_base),
    .in_seg_limit   (in_seg_limit),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_used_slot  (out_used_slot),
    .out_selector   (out_selector),
    .out_entry_word (out_entry_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // shadow copy of the table: entry count register and one present flag per entry
  logic [sdt_pkg::CNT_W-1:0] shadow_count;
  bit                        shadow_live [NUM_ENTRIES];

  request_t request_q [$];   // items still to be offered
  outcome_t outcome_q [$];   // results owed by the block, oldest first

  int  items_queued;
  int  items_taken;
  int  results_seen;
  int  mismatches;
  int  n_ok, n_range, n_full;
  int  sender_idle_pct;
  int  receiver_idle_pct;
  bit  in_took;              // the offered item went in at the last rising edge
  bit  hold_request;
  bit  hold_done;
  int  hold_left;
  int  quiet_cycles;

  // count settings per random phase, with the mix of request kinds in percent
  int phase_count   [NUM_PHASES] = '{8192, 5, 256, 1, 0, 255};
  int phase_items   [NUM_PHASES] = '{100, 120, 120, 40, 20, 60};
  int phase_add_pct [NUM_PHASES] = '{20, 20, 25, 30, 25, 25};
  int phase_res_pct [NUM_PHASES] = '{35, 35, 30, 30, 25, 35};
  int phase_del_pct [NUM_PHASES] = '{25, 30, 25, 20, 25, 20};

  // expected result for one request; also advances the shadow present flags
  function automatic outcome_t descriptor_outcome(request_t r);
    outcome_t    res;
    int          usable;
    int          free_slot;
    logic        gran;
    logic [19:0] lim20;
    logic [sdt_pkg::WORD_W-1:0] word;
    res = '0;
    usable = (shadow_count < NUM_ENTRIES) ? int'(shadow_count) : NUM_ENTRIES;

    // descriptor as add or reserve would write it
    gran  = (r.limit >= 32'd4096);
    lim20 = gran ? r.limit[31:12] : r.limit[19:0];
    word  = '0;
    word[15:0]  = lim20[15:0];
    word[39:16] = r.base[23:0];
    word[43:40] = r.typ;
    word[44]    = !r.sys;        // code or data segments carry S set
    word[46:45] = r.priv;
    word[47]    = 1'b1;          // present
    word[51:48] = lim20[19:16];
    word[54]    = 1'b1;          // 32-bit default size
    word[55]    = gran;
    word[63:56] = r.base[31:24];

    if (r.kind == sdt_pkg::KIND_RESERVE) begin
      // lowest free entry, entry zero never handed out
      free_slot = -1;
      for (int i = 1; i < usable; i++)
        if (free_slot < 0 && !shadow_live[i]) free_slot = i;
      if (free_slot < 0) begin
        res.status = sdt_pkg::ST_FULL;
      end else begin
        shadow_live[free_slot] = 1'b1;
        res.used_slot = free_slot[sdt_pkg::SLOT_W-1:0];
        res.word      = word;
      end
      return res;
    end

    res.used_slot = r.slot;
    if (int'(r.slot) >= usable) begin
      res.status = sdt_pkg::ST_RANGE;
      return res;
    end
    case (r.kind)
      sdt_pkg::KIND_ADD: begin
        shadow_live[r.slot[IDX_W-1:0]] = 1'b1;
        res.word = word;
      end
      sdt_pkg::KIND_DELETE: begin
        shadow_live[r.slot[IDX_W-1:0]] = 1'b0;
      end
      default: begin
        res.selector = {r.slot, 1'b0, r.priv};  // table indicator stays zero
      end
    endcase
    return res;
  endfunction

  task automatic push_req(input logic [1:0] kind, input int slot, input logic [1:0] priv,
                          input logic sys, input logic [3:0] typ,
                          input logic [31:0] base, input logic [31:0] limit);
    request_t r;
    r.kind  = kind;
    r.slot  = slot[sdt_pkg::SLOT_W-1:0];
    r.priv  = priv;
    r.sys   = sys;
    r.typ   = typ;
    r.base  = base;
    r.limit = limit;
    request_q.push_back(r);
    items_queued++;
  endtask

  // random requests aimed at a given count; slots mostly land inside the table
  task automatic push_random(input int n, input int count, input int add_pct,
                             input int res_pct, input int del_pct);
    int          usable;
    int          pick;
    int          slot;
    logic [1:0]  kind;
    logic [31:0] limit;
    usable = (count < NUM_ENTRIES) ? count : NUM_ENTRIES;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < add_pct)                           kind = sdt_pkg::KIND_ADD;
      else if (pick < add_pct + res_pct)            kind = sdt_pkg::KIND_RESERVE;
      else if (pick < add_pct + res_pct + del_pct)  kind = sdt_pkg::KIND_DELETE;
      else                                          kind = sdt_pkg::KIND_SELECTOR;
      pick = $urandom_range(99);
      if (usable > 0 && pick < 70) slot = $urandom_range(usable - 1, 0);
      else if (pick < 85)          slot = $urandom_range(8191, usable);
      else                         slot = $urandom_range(8191, 0);
      pick = $urandom_range(99);
      if (pick < 40)      limit = $urandom_range(4095, 0);
      else if (pick < 60) limit = $urandom_range(4100, 4090);   // around the granularity switch
      else                limit = $urandom;
      push_req(kind, slot, 2'($urandom), 1'($urandom), 4'($urandom), $urandom, limit);
    end
  endtask

  task automatic write_count(input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[sdt_pkg::CNT_W-1:0];
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    shadow_count = value[sdt_pkg::CNT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // block is idle once every queued item went in and every result came back
  task automatic wait_idle();
    while (items_taken != items_queued || outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // sender: offers the next pending item once the previous one went in
  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        r = request_q.pop_front();
        in_valid      <= 1'b1;
        in_kind       <= r.kind;
        in_slot_index <= r.slot;
        in_privilege  <= r.priv;
        in_is_system  <= r.sys;
        in_seg_type   <= r.typ;
        in_seg_base   <= r.base;
        in_seg_limit  <= r.limit;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random backpressure, plus one long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    request_t r;
    outcome_t want;
    outcome_t got;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        r = {in_kind, in_slot_index, in_privilege, in_is_system, in_seg_type,
             in_seg_base, in_seg_limit};
        want = descriptor_outcome(r);
        case (want.status)
          sdt_pkg::ST_OK:    n_ok++;
          sdt_pkg::ST_RANGE: n_range++;
          default:           n_full++;
        endcase
        outcome_q.push_back(want);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        got = {out_status, out_used_slot, out_selector, out_entry_word};
        results_seen++;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing outstanding: status %0d slot %0d sel %h word %h",
                     got.status, got.used_slot, got.selector, got.word);
        end else begin
          want = outcome_q.pop_front();
          if (got.status !== want.status || got.used_slot !== want.used_slot ||
              got.selector !== want.selector || got.word !== want.word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d mismatch", results_seen);
              $display("  status    exp %0d got %0d", want.status, got.status);
              $display("  used_slot exp %0d got %0d", want.used_slot, got.used_slot);
              $display("  selector  exp %h got %h", want.selector, got.selector);
              $display("  word      exp %h got %h", want.word, got.word);
            end
          end
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, outcome_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = sdt_pkg::KIND_ADD;
    in_slot_index = '0;
    in_privilege  = '0;
    in_is_system  = 1'b0;
    in_seg_type   = '0;
    in_seg_base   = '0;
    in_seg_limit  = '0;
    out_ready     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    shadow_count  = '0;
    quiet_cycles  = 0;
    // sender mostly busy, receiver mostly stalling to start with
    sender_idle_pct   = 22;
    receiver_idle_pct = 78;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // count is zero out of reset: every request is rejected
    push_req(sdt_pkg::KIND_ADD,      0, 2'd0, 1'b0, 4'h0, 32'h0, 32'h0);
    push_req(sdt_pkg::KIND_RESERVE,  0, 2'd3, 1'b1, 4'hf, 32'hffffffff, 32'hffffffff);
    push_req(sdt_pkg::KIND_SELECTOR, 0, 2'd3, 1'b0, 4'h0, 32'h0, 32'h0);
    push_req(sdt_pkg::KIND_DELETE,   0, 2'd0, 1'b0, 4'h0, 32'h0, 32'h0);
    wait_idle();

    write_count(8);
    // add at entry zero, all-ones fields, then the limit either side of 4 KiB
    push_req(sdt_pkg::KIND_ADD, 0, 2'd3, 1'b1, 4'hf, 32'hffffffff, 32'hffffffff);
    push_req(sdt_pkg::KIND_ADD, 7, 2'd0, 1'b0, 4'h0, 32'h0, 32'd4095);
    push_req(sdt_pkg::KIND_ADD, 7, 2'd2, 1'b0, 4'ha, 32'h12345678, 32'd4096);
    // first slot past the count, and the largest index
    push_req(sdt_pkg::KIND_ADD, 8,    2'd1, 1'b0, 4'h2, 32'h0, 32'h0);
    push_req(sdt_pkg::KIND_ADD, 8191, 2'd1, 1'b1, 4'h9, 32'h0, 32'h0);
    // reserve walks slots 1..6, then the table is full
    for (int k = 0; k < 7; k++)
      push_req(sdt_pkg::KIND_RESERVE, 0, 2'(k), 1'(k), 4'(k * 3),
               32'h01000000 * k, 32'h100 << k);
    // a freed slot is handed out again
    push_req(sdt_pkg::KIND_DELETE,   3, 2'd0, 1'b0, 4'h0, 32'h0, 32'h0);
    push_req(sdt_pkg::KIND_RESERVE,  0, 2'd1, 1'b0, 4'h3, 32'hdeadbeef, 32'h000fffff);
    push_req(sdt_pkg::KIND_SELECTOR, 7, 2'd3, 1'b0, 4'h0, 32'h0, 32'h0);
    push_req(sdt_pkg::KIND_SELECTOR, 0, 2'd0, 1'b0, 4'h0, 32'h0, 32'h0);
    push_req(sdt_pkg::KIND_SELECTOR, 8191, 2'd3, 1'b0, 4'h0, 32'h0, 32'h0);
    push_req(sdt_pkg::KIND_DELETE,   8, 2'd0, 1'b0, 4'h0, 32'h0, 32'h0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // idling pattern: receiver-starved, then sender-starved, then full rate
      if (p < 2) begin
        sender_idle_pct   = 22;
        receiver_idle_pct = 78;
      end else if (p < 4) begin
        sender_idle_pct   = 78;
        receiver_idle_pct = 22;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      write_count(phase_count[p]);
      // the capped phase fills the whole table through reserve before mixing
      if (p == 0)
        for (int k = 0; k < 250; k++)
          push_req(sdt_pkg::KIND_RESERVE, $urandom_range(8191, 0), 2'($urandom),
                   1'($urandom), 4'($urandom), $urandom, $urandom);
      push_random(phase_items[p], phase_count[p], phase_add_pct[p], phase_res_pct[p],
                  phase_del_pct[p]);
      // back up the block while the sender keeps offering at full rate
      if (p == NUM_PHASES - 1) hold_request = 1'b1;
      wait_idle();
    end

    $display("%0d requests, %0d results checked over counts 0 to 8192 and three idling patterns",
             items_taken, results_seen);
    $display("status mix: %0d ok, %0d out of range, %0d table full; %0d mismatches",
             n_ok, n_range, n_full, mismatches);
    if (mismatches == 0 && outcome_q.size() == 0 && results_seen == items_taken) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
